// File: rtl/tte_pkg.sv
package tte_pkg;

  localparam int TIME_BITS     = 32;
  localparam int WINDOW_TAPS   = 4;
  localparam int INTERVAL_BITS = 16;
  localparam int SLOT_BITS     = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
  localparam int COUNT_BITS    = $clog2(WINDOW_TAPS + 1);
  localparam int SUM_BITS      = INTERVAL_BITS + $clog2(WINDOW_TAPS);
  localparam int TAP_NUMERATOR = 6000000;
  localparam int DIVIDEND_BITS = $clog2(TAP_NUMERATOR * WINDOW_TAPS + 1);
  localparam int BPM_BITS      = 23;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0]  REG_MIN_INTERVAL = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0]  REG_MAX_INTERVAL = CFG_IDX_BITS'(1);
  localparam logic [CFG_DATA_BITS-1:0] MIN_INTERVAL_RESET = CFG_DATA_BITS'(250);
  localparam logic [CFG_DATA_BITS-1:0] MAX_INTERVAL_RESET = CFG_DATA_BITS'(2000);

  localparam logic [DIVIDEND_BITS-1:0] NUMERATOR_VEC = DIVIDEND_BITS'(TAP_NUMERATOR);
  localparam logic [SLOT_BITS-1:0]     LAST_SLOT     = SLOT_BITS'(WINDOW_TAPS - 1);
  localparam logic [COUNT_BITS-1:0]    FULL_COUNT    = COUNT_BITS'(WINDOW_TAPS);
  localparam logic [DIV_CNT_BITS-1:0]  DIV_LAST      = DIV_CNT_BITS'(DIVIDEND_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_RESULT
  } tte_state_t;

endpackage

// File: rtl/tte_if.sv
interface tte_tap_if import tte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] tap_time_ms;

  modport source (output valid, output tap_time_ms, input ready);
  modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tte_tempo_if import tte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  tempo_updated;
  logic [BPM_BITS-1:0]   bpm_centi;
  logic [COUNT_BITS-1:0] taps_in_window;

  modport source (output valid, output tempo_updated, output bpm_centi,
                  output taps_in_window, input ready);
  modport sink   (input valid, input tempo_updated, input bpm_centi,
                  input taps_in_window, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tap_tempo_estimator_core.sv
// Tap tempo estimator.
// in_chan carries one tap per transaction: the free-running millisecond counter
// value at the tap. out_chan returns exactly one result transaction per tap:
// tempo_updated, bpm_centi (hundredths of BPM, truncated, zero without update)
// and taps_in_window. cfg_chan writes min_interval_ms (index 0) and
// max_interval_ms (index 1); other indexes are ignored. cfg_chan is always ready
// and must be written only while no tap is in flight (not enforced by the core).
// A tap that updates the tempo goes from acceptance to the result register
// through the interval check, the window sum and one restoring divider step per
// dividend bit (25 steps through a single shared subtractor), then the output load.
// Other taps go straight to the output load. in_chan is ready only while the
// sequencer is idle, so one tap is handled at a time and a new tap is accepted
// only after the last one has loaded its result. The result register holds a
// finished transaction while the receiver stalls; the next tap is accepted
// meanwhile and waits in its result state.
// Reset restores the limits to 250 and 2000 ms, forgets the previous tap and
// empties the window; window entries are not cleared since only entries written
// after the last emptying are read.
module tap_tempo_estimator_core import tte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tte_tap_if.sink     in_chan,
  tte_tempo_if.source out_chan,
  tte_cfg_if.sink     cfg_chan
);

  tte_state_t state_r, state_nxt;

  logic [CFG_DATA_BITS-1:0] min_r, max_r;
  logic [TIME_BITS-1:0]     prev_r;
  logic                     seen_r;
  logic [INTERVAL_BITS-1:0] window_r [WINDOW_TAPS];
  logic [COUNT_BITS-1:0]    count_r, count_nxt;
  logic [SLOT_BITS-1:0]     slot_r, slot_nxt;
  logic [SUM_BITS-1:0]      sum_r, sum_nxt;
  logic [INTERVAL_BITS-1:0] interval_r;
  logic [INTERVAL_BITS-1:0] old_r;
  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [SUM_BITS-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_BITS-1:0]  step_r, step_nxt;
  logic                     upd_r, upd_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_upd_r;
  logic [BPM_BITS-1:0]      out_bpm_r;
  logic [COUNT_BITS-1:0]    out_cnt_r;

  logic                     in_fire;
  logic                     win_we;
  logic                     out_load;
  logic [TIME_BITS-1:0]     interval;
  logic                     in_range;
  logic [SUM_BITS:0]        trial;
  logic [SUM_BITS:0]        diff;
  logic                     ge;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign interval = in_chan.tap_time_ms - prev_r;
  assign in_range = (interval > TIME_BITS'(min_r)) && (interval < TIME_BITS'(max_r));

  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, sum_r};
  assign ge    = !diff[SUM_BITS];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    win_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          upd_nxt = 1'b0;
          if (!seen_r) begin
            state_nxt = ST_RESULT;
          end else if (in_range) begin
            win_we    = 1'b1;
            state_nxt = ST_UPDATE;
          end else begin
            count_nxt = '0;
            slot_nxt  = '0;
            sum_nxt   = '0;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_UPDATE: begin
        if (count_r >= FULL_COUNT) begin
          sum_nxt = sum_r + SUM_BITS'(interval_r) - SUM_BITS'(old_r);
        end else begin
          sum_nxt   = sum_r + SUM_BITS'(interval_r);
          count_nxt = count_r + COUNT_BITS'(1);
        end
        slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_BITS'(1);
        quo_nxt   = DIVIDEND_BITS'(NUMERATOR_VEC * DIVIDEND_BITS'(count_nxt));
        rem_nxt   = '0;
        step_nxt  = '0;
        upd_nxt   = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        rem_nxt  = ge ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
        quo_nxt  = {quo_r[DIVIDEND_BITS-2:0], ge};
        step_nxt = step_r + DIV_CNT_BITS'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= MIN_INTERVAL_RESET;
      max_r       <= MAX_INTERVAL_RESET;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      count_r     <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        prev_r <= in_chan.tap_time_ms;
        seen_r <= 1'b1;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == REG_MIN_INTERVAL) begin
          min_r <= cfg_chan.data;
        end else if (cfg_chan.index == REG_MAX_INTERVAL) begin
          max_r <= cfg_chan.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (win_we) begin
      window_r[slot_r] <= interval[INTERVAL_BITS-1:0];
      old_r            <= window_r[slot_r];
      interval_r       <= interval[INTERVAL_BITS-1:0];
    end
    if (out_load) begin
      out_upd_r <= upd_r;
      out_bpm_r <= upd_r ? quo_r[BPM_BITS-1:0] : '0;
      out_cnt_r <= count_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.tempo_updated  = out_upd_r;
  assign out_chan.bpm_centi      = out_bpm_r;
  assign out_chan.taps_in_window = out_cnt_r;

endmodule

// File: rtl/tte_checker.sv
module tte_checker import tte_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  tempo_updated,
  input logic [BPM_BITS-1:0]   bpm_centi,
  input logic [COUNT_BITS-1:0] taps_in_window
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bpm_centi) &&
      $stable(tempo_updated) && $stable(taps_in_window))
    else $error("Result transaction changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Tap accepted while another tap is in flight.");

  a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tempo_updated |-> bpm_centi == '0)
    else $error("Tempo reported without an update.");

  a_update_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tempo_updated |-> taps_in_window != '0 &&
      taps_in_window <= COUNT_BITS'(WINDOW_TAPS))
    else $error("Window count inconsistent with a tempo update.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind tap_tempo_estimator_core tte_checker u_tte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .tempo_updated  (out_chan.tempo_updated),
  .bpm_centi      (out_chan.bpm_centi),
  .taps_in_window (out_chan.taps_in_window)
);

// File: tb/tte_tempo_checker.sv
module tte_tempo_checker import tte_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     tap_valid,
  input  logic                     tap_ready,
  input  logic [TIME_BITS-1:0]     tap_time,
  input  logic                     res_valid,
  input  logic                     res_ready,
  input  logic                     res_updated,
  input  logic [BPM_BITS-1:0]      res_bpm,
  input  logic [COUNT_BITS-1:0]    res_taps,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  updated;
    logic [BPM_BITS-1:0]   bpm;
    logic [COUNT_BITS-1:0] taps;
  } tempo_result_t;

  tempo_result_t              pending_tempos[$];
  int                         mismatches = 0;

  logic [CFG_DATA_BITS-1:0]   min_limit;
  logic [CFG_DATA_BITS-1:0]   max_limit;
  logic [TIME_BITS-1:0]       last_tap;
  logic                       seen_tap;
  logic [INTERVAL_BITS-1:0]   intervals[WINDOW_TAPS];
  logic [COUNT_BITS-1:0]      held;
  logic [SLOT_BITS-1:0]       next_slot;
  logic [SUM_BITS-1:0]        interval_sum;

  function automatic tempo_result_t estimate_tempo(input logic [TIME_BITS-1:0] now);
    tempo_result_t          res;
    logic [TIME_BITS-1:0]   gap;
    logic [SLOT_BITS-1:0]   slot;
    longint unsigned        scaled;
    res = '0;
    if (seen_tap) begin
      gap = now - last_tap;
      if (gap > TIME_BITS'(min_limit) && gap < TIME_BITS'(max_limit)) begin
        slot = next_slot;
        if (held >= FULL_COUNT) begin
          interval_sum = interval_sum - SUM_BITS'(intervals[slot]);
        end else begin
          held = held + 1'b1;
        end
        intervals[slot] = gap[INTERVAL_BITS-1:0];
        interval_sum = interval_sum + SUM_BITS'(gap[INTERVAL_BITS-1:0]);
        next_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        scaled = longint'(TAP_NUMERATOR) * longint'(held);
        if (interval_sum != 0) begin
          res.bpm = BPM_BITS'(scaled / longint'(interval_sum));
        end
        res.updated = 1'b1;
      end else begin
        held = '0;
        next_slot = '0;
        interval_sum = '0;
      end
    end
    last_tap = now;
    seen_tap = 1'b1;
    res.taps = held;
    return res;
  endfunction

  always @(posedge clk) begin
    tempo_result_t want;
    if (!rst_n) begin
      min_limit = MIN_INTERVAL_RESET;
      max_limit = MAX_INTERVAL_RESET;
      last_tap = '0;
      seen_tap = 1'b0;
      held = '0;
      next_slot = '0;
      interval_sum = '0;
      pending_tempos.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_limit = cfg_data;
          REG_MAX_INTERVAL: max_limit = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (pending_tempos.size() == 0) begin
          $error("tempo transaction arrived with no tap waiting for it");
          mismatches++;
        end else begin
          want = pending_tempos.pop_front();
          if (res_updated !== want.updated) begin
            $error("tempo_updated: expected %0d, actual %0d", want.updated, res_updated);
            mismatches++;
          end
          if (res_bpm !== want.bpm) begin
            $error("bpm_centi: expected %0d, actual %0d", want.bpm, res_bpm);
            mismatches++;
          end
          if (res_taps !== want.taps) begin
            $error("taps_in_window: expected %0d, actual %0d", want.taps, res_taps);
            mismatches++;
          end
        end
      end
      if (tap_valid && tap_ready) begin
        pending_tempos.insert(pending_tempos.size(), estimate_tempo(tap_time));
      end
    end
    fail_count <= mismatches;
    outstanding <= pending_tempos.size();
  end

endmodule

// File: tb/tap_tempo_estimator_core_test.sv
module tap_tempo_estimator_core_test;
  import tte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_TOP = '1;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  bit   hold_results = 1'b0;
  int   fail_count;
  int   outstanding;
  int   burst_left = 1;
  logic [TIME_BITS-1:0] last_sent = '0;

  tte_tap_if   tap_bus();
  tte_tempo_if tempo_bus();
  tte_cfg_if   cfg_bus();

  tap_tempo_estimator_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (tap_bus),
    .out_chan (tempo_bus),
    .cfg_chan (cfg_bus)
  );

  tte_tempo_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tap_valid   (tap_bus.valid),
    .tap_ready   (tap_bus.ready),
    .tap_time    (tap_bus.tap_time_ms),
    .res_valid   (tempo_bus.valid),
    .res_ready   (tempo_bus.ready),
    .res_updated (tempo_bus.tempo_updated),
    .res_bpm     (tempo_bus.bpm_centi),
    .res_taps    (tempo_bus.taps_in_window),
    .cfg_valid   (cfg_bus.valid),
    .cfg_ready   (cfg_bus.ready),
    .cfg_index   (cfg_bus.index),
    .cfg_data    (cfg_bus.data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver picks a new random stall behavior whenever its current mode runs out.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    mode = RX_ALWAYS;
    mode_left = 0;
    phase = 0;
    tempo_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        tempo_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(3, 0));
          mode_left = $urandom_range(120, 10);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   tempo_bus.ready <= 1'b1;
          RX_COIN:     tempo_bus.ready <= 1'($urandom_range(1, 0));
          RX_SPARSE:   tempo_bus.ready <= ($urandom_range(3, 0) == 0);
          RX_PERIODIC: tempo_bus.ready <= (phase % 7) < 3;
          default:     tempo_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_tap(input logic [TIME_BITS-1:0] stamp);
    tap_bus.valid <= 1'b1;
    tap_bus.tap_time_ms <= stamp;
    last_sent = stamp;
    do @(posedge clk); while (!(tap_bus.valid && tap_bus.ready));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      tap_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic tap_paced(input logic [TIME_BITS-1:0] stamp);
    send_tap(stamp);
    burst_left--;
    if (burst_left <= 0) begin
      idle_sender(($urandom_range(3, 0) == 0) ? $urandom_range(40, 8) : $urandom_range(4, 0));
      burst_left = $urandom_range(12, 1);
    end
  endtask

  task automatic tap_after(input logic [TIME_BITS-1:0] delta);
    tap_paced(last_sent + delta);
  endtask

  task automatic drain();
    tap_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] lo_lim,
                           input logic [CFG_DATA_BITS-1:0] hi_lim,
                           input int n_taps, input bit with_hold);
    int pick;
    int low_iv;
    int high_iv;
    drain();
    write_reg(REG_MIN_INTERVAL, lo_lim);
    write_reg(REG_MAX_INTERVAL, hi_lim);
    if ($urandom_range(1, 0) == 1) begin
      write_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_TOP, REG_MAX_INTERVAL + 1)),
                CFG_DATA_BITS'($urandom));
    end
    low_iv = int'(lo_lim) + 1;
    high_iv = int'(hi_lim) - 1;
    for (int i = 0; i < n_taps; i++) begin
      if (with_hold && i == 5) begin
        hold_results <= 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 75 && low_iv <= high_iv) begin
        tap_after(TIME_BITS'($urandom_range(high_iv, low_iv)));
      end else if (pick < 85) begin
        tap_after(pick[0] ? TIME_BITS'(lo_lim) : TIME_BITS'(hi_lim));
      end else if (pick < 93) begin
        tap_after(TIME_BITS'($urandom));
      end else begin
        tap_paced(TIME_BITS'($urandom));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    tap_bus.valid <= 1'b0;
    tap_bus.tap_time_ms <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default limits: first tap at time zero, both boundaries, window rollover,
    // a repeated timestamp and a counter wrap.
    send_tap('0);
    send_tap(TIME_BITS'(1000));
    tap_after(TIME_BITS'(251));
    tap_after(TIME_BITS'(1999));
    tap_after(TIME_BITS'(MIN_INTERVAL_RESET));
    tap_after(TIME_BITS'(600));
    tap_after(TIME_BITS'(MAX_INTERVAL_RESET));
    for (int i = 3; i <= 7; i++) tap_after(TIME_BITS'(i * 100));
    tap_after('0);
    tap_paced(32'hFFFF_FE00);
    tap_paced(32'h0000_0100);
    tap_paced('1);
    tap_after(TIME_BITS'(1000));

    drain();
    write_reg(REG_SPARE_TOP, '1);
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_MAX_INTERVAL, '1);
    tap_after(TIME_BITS'(1));
    tap_after(TIME_BITS'(65534));
    tap_after(TIME_BITS'(65535));
    for (int i = 0; i < 5; i++) tap_after(TIME_BITS'(1));

    run_phase(MIN_INTERVAL_RESET, MAX_INTERVAL_RESET, 80, 1'b1);
    run_phase('0, '1, 60, 1'b0);
    run_phase(16'd0, 16'd3, 50, 1'b0);
    run_phase(16'd65533, '1, 30, 1'b0);
    run_phase('1, 16'd1, 30, 1'b0);
    run_phase(16'd1000, 16'd1000, 30, 1'b0);
    for (int p = 0; p < 6; p++) begin
      logic [CFG_DATA_BITS-1:0] lo;
      logic [CFG_DATA_BITS-1:0] hi;
      lo = CFG_DATA_BITS'($urandom_range(600, 1));
      hi = CFG_DATA_BITS'($urandom_range(int'(lo) + 3000, int'(lo) + 2));
      run_phase(lo, hi, 60, 1'b0);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tte_pkg.sv
rtl/tte_if.sv
rtl/tap_tempo_estimator_core.sv
rtl/tte_checker.sv
tb/tte_tempo_checker.sv
tb/tap_tempo_estimator_core_test.sv
